// ===== hw/rtl/decimating_complex_fir_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimating complex FIR filter
// Shared shorthand for concurrent checks clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMATING_COMPLEX_FIR_TOP_DEFINES_SVH
`define DECIMATING_COMPLEX_FIR_TOP_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define DCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never occurs outside reset.
`define DCF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Types and fixed constants shared by the decimating complex FIR modules.
// ----------------------------------------------------------------------------
package dcf_pkg;

  // Fixed register widths of the configuration port.
  localparam int unsigned FACTOR_W = 9;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // Largest decimation factor that takes effect; larger values clamp to it.
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 9'd256;

  // Register map, one register every four bytes.
  typedef enum logic [1:0] {
    REG_DEC_FACTOR,
    REG_COEF_INDEX,
    REG_COEF_REAL,
    REG_COEF_IMAG
  } reg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // store the incoming word and set up a new pass
    logic step;     // issue the reads for one tap
    logic finish;   // round, saturate and load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_tap;   // the tap being issued is the final one
    logic busy;       // multiply-accumulate pipeline still holds taps
    logic slot_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

// ===== hw/rtl/dcf_ram.sv =====
// ----------------------------------------------------------------------------
// dcf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dcf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcf_ctrl
// Controller: input handshake, decimation counter and the sequence of one
// multiply-accumulate pass.
// ----------------------------------------------------------------------------
`include "decimating_complex_fir_top_defines.svh"

module dcf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic [dcf_pkg::FACTOR_W-1:0]  factor_i,
  input  dcf_pkg::dp_status_t           status_i,
  output dcf_pkg::dp_cmd_t              cmd_o
);

  import dcf_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [FACTOR_W-1:0] eff_factor;
  logic [FACTOR_W-1:0] cnt_inc;
  logic                emit;
  logic                accept;

  // State and decimation count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Clamp the factor, decide on emission and sequence the pass.
  always_comb begin
    eff_factor = factor_i;
    if (factor_i == '0) begin
      eff_factor = FACTOR_W'(1);
    end else if (factor_i > FACTOR_MAX) begin
      eff_factor = FACTOR_MAX;
    end
    cnt_inc = FACTOR_W'(cnt_q) + FACTOR_W'(1);
    emit    = (cnt_inc >= eff_factor);

    state_d        = state_q;
    cnt_d          = cnt_q;
    sample_ready_o = 1'b0;
    accept         = 1'b0;
    cmd_o          = '0;

    case (state_q)
      ST_IDLE: begin
        sample_ready_o = 1'b1;
        if (sample_valid_i) begin
          accept       = 1'b1;
          cmd_o.accept = 1'b1;
          if (emit) begin
            cnt_d   = '0;
            state_d = ST_MAC;
          end else begin
            cnt_d = cnt_inc[COUNT_W-1:0];
          end
        end
      end
      ST_MAC: begin
        cmd_o.step = 1'b1;
        if (status_i.last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A word that completes the decimation interval starts a pass.
  `DCF_ASSERT(a_emit_starts_pass, (accept && emit) |=> (state_q == ST_MAC),
              "emitting word did not start a pass")
  // A word that does not emit leaves the controller ready for the next one.
  `DCF_ASSERT(a_skip_stays_idle, (accept && !emit) |=> (state_q == ST_IDLE && cnt_q != '0),
              "non-emitting word did not return to idle with a counted sample")
  // The pass runs until the datapath reports the last tap.
  `DCF_ASSERT(a_mac_holds, (state_q == ST_MAC && !status_i.last_tap) |=> (state_q == ST_MAC),
              "pass left before the last tap")
  // Results are only loaded once the pipeline is empty.
  `DCF_ASSERT_NEVER(a_finish_while_busy, cmd_o.finish && status_i.busy,
                    "result loaded while taps were still in flight")

endmodule

// ===== hw/rtl/dcf_dp.sv =====
// ----------------------------------------------------------------------------
// dcf_dp
// Datapath: delay line and coefficient memories, a pipelined complex
// multiply-accumulate, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
`include "decimating_complex_fir_top_defines.svh"

module dcf_dp #(
  parameter int unsigned TAPS        = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dcf_pkg::dp_cmd_t                cmd_i,
  output dcf_pkg::dp_status_t             status_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_im_i,
  input  logic                            coef_we_i,
  input  logic [$clog2(TAPS)-1:0]         coef_addr_i,
  input  logic [COEF_BITS-1:0]            coef_re_i,
  input  logic [COEF_BITS-1:0]            coef_im_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]   out_re_o,
  output logic signed [SAMPLE_BITS-1:0]   out_im_o
);

  import dcf_pkg::*;

  localparam int unsigned AW      = $clog2(TAPS);
  localparam int unsigned FILL_W  = $clog2(TAPS + 1);
  localparam int unsigned PROD_W  = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned TERM_W  = PROD_W + 1;
  localparam int unsigned ACC_RAW = PROD_W + AW + 2;
  localparam int unsigned ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;

  localparam logic [AW-1:0]     LAST_ADDR = AW'(TAPS - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS);

  localparam logic signed [ACC_W-1:0] RND_OFF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_BITS - 2);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // Pointers and fill count.
  logic [AW-1:0]     wp_q;
  logic [AW-1:0]     rd_ptr_q;
  logic [AW-1:0]     tap_q;
  logic [FILL_W-1:0] fill_q;

  // Memory read data.
  logic [2*SAMPLE_BITS-1:0] line_rd;
  logic [2*COEF_BITS-1:0]   coef_rd;

  // Pipeline valid bits and payload.
  logic                       s1_q, s2_q, s3_q;
  logic                       mask_q;
  logic signed [SAMPLE_BITS-1:0] xr, xi;
  logic signed [COEF_BITS-1:0]   cr, ci;
  logic signed [PROD_W-1:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [TERM_W-1:0]   term_re_q, term_im_q;
  logic signed [ACC_W-1:0]    acc_re_q, acc_im_q;

  // Output register.
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_re_q, out_im_q;

  // Rounds half up at the coefficient binary point and clamps to sample range.
  function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shf;
    logic [SAMPLE_BITS-1:0]  res;
    rnd = acc + RND_OFF;
    shf = rnd >>> (COEF_BITS - 1);
    if (shf > SAT_HI) begin
      res = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shf < SAT_LO) begin
      res = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res = shf[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  // The delay line holds {imag, real}; the coefficient store {real, imag}.
  dcf_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wp_q),
    .wdata_i ({sample_im_i, sample_re_i}),
    .re_i    (cmd_i.step),
    .raddr_i (rd_ptr_q),
    .rdata_o (line_rd)
  );

  dcf_ram #(
    .WIDTH (2 * COEF_BITS),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we_i),
    .waddr_i (coef_addr_i),
    .wdata_i ({coef_re_i, coef_im_i}),
    .re_i    (cmd_i.step),
    .raddr_i (tap_q),
    .rdata_o (coef_rd)
  );

  // Write pointer, read pointer, tap counter and fill count. Entries are
  // written in address order from zero, so those below the fill count are
  // exactly the ones written since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rd_ptr_q <= '0;
      tap_q    <= '0;
      fill_q   <= '0;
    end else if (cmd_i.accept) begin
      wp_q     <= (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
      rd_ptr_q <= wp_q;
      tap_q    <= '0;
      if (fill_q != FILL_FULL) begin
        fill_q <= fill_q + 1'b1;
      end
    end else if (cmd_i.step) begin
      rd_ptr_q <= (rd_ptr_q == '0) ? LAST_ADDR : rd_ptr_q - 1'b1;
      tap_q    <= tap_q + 1'b1;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
      s3_q <= 1'b0;
    end else begin
      s1_q <= cmd_i.step;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // Operand selection; an entry never written reads as zero.
  always_comb begin
    xr = mask_q ? signed'(line_rd[SAMPLE_BITS-1:0])             : '0;
    xi = mask_q ? signed'(line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
    cr = signed'(coef_rd[2*COEF_BITS-1:COEF_BITS]);
    ci = signed'(coef_rd[COEF_BITS-1:0]);
  end

  // Multiply, combine and accumulate stages.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      mask_q <= (FILL_W'(rd_ptr_q) < fill_q);
    end
    if (s1_q) begin
      p_rr_q <= xr * cr;
      p_ii_q <= xi * ci;
      p_ri_q <= xr * ci;
      p_ir_q <= xi * cr;
    end
    if (s2_q) begin
      term_re_q <= TERM_W'(p_rr_q) - TERM_W'(p_ii_q);
      term_im_q <= TERM_W'(p_ri_q) + TERM_W'(p_ir_q);
    end
    if (cmd_i.accept) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (s3_q) begin
      acc_re_q <= acc_re_q + ACC_W'(term_re_q);
      acc_im_q <= acc_im_q + ACC_W'(term_im_q);
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_re_q <= signed'(round_sat(acc_re_q));
      out_im_q <= signed'(round_sat(acc_im_q));
    end
  end

  // Status back to the controller.
  always_comb begin
    status_o.last_tap  = (tap_q == LAST_ADDR);
    status_o.busy      = s1_q | s2_q | s3_q;
    status_o.slot_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

  // The fill count saturates at the delay line depth.
  `DCF_ASSERT(a_fill_bound, fill_q <= FILL_FULL, "fill count beyond delay line depth")
  // Every pass begins with the newest sample and the first tap.
  `DCF_ASSERT(a_pass_start, cmd_i.accept |=> (tap_q == '0 && rd_ptr_q == $past(wp_q)),
              "pass did not start at the newest sample")
  // A result is never loaded over a word still waiting on the output.
  `DCF_ASSERT_NEVER(a_no_overwrite, cmd_i.finish && out_valid_q && !out_ready_i,
                    "output word overwritten")

endmodule

// ===== hw/rtl/decimating_complex_fir_top.sv =====
// ----------------------------------------------------------------------------
// decimating_complex_fir_top
// Decimating complex FIR filter with an APB-style coefficient and control port.
// ----------------------------------------------------------------------------
// Each accepted word is one complex sample that enters a circular delay line
// of TAPS entries. Every Nth sample (N from the decimation factor register,
// zero acting as one and values above 256 as 256) starts a pass that
// multiplies the newest TAPS samples by the coefficient store, tap 0 against
// the newest sample, and delivers one rounded and saturated output word. A
// sample that does not complete the interval leaves the filter ready for the
// next one. A sample that does holds off the next sample for its pass: the
// accept cycle, one memory read of the delay line and the coefficient store
// per tap, a drain of the multiply, combine and accumulate pipeline, and a
// rounding cycle that also waits while a previous output word is not yet
// taken. Coefficients load by writing coef_index, coef_real and then
// coef_imag, the last write storing the pair. The user must change registers
// only while the filter is idle; the block itself does not enforce this;
// coefficient store entries must be written before a pass reads them.
module decimating_complex_fir_top #(
  parameter int unsigned TAPS        = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample input channel.
  input  logic                            sample_valid_i,
  output logic                            sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_im_i,
  // Filtered output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   out_re_o,
  output logic signed [SAMPLE_BITS-1:0]   out_im_o,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dcf_pkg::APB_AW-1:0]      paddr,
  input  logic [dcf_pkg::APB_DW-1:0]      pwdata,
  output logic [dcf_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  import dcf_pkg::*;

  localparam int unsigned AW = $clog2(TAPS);

  logic [FACTOR_W-1:0]  factor_q;
  logic [IDX_W-1:0]     coef_index_q;
  logic [COEF_BITS-1:0] coef_re_q;
  logic [COEF_BITS-1:0] coef_im_q;
  reg_idx_e             reg_idx;
  logic                 reg_wr;
  logic                 coef_we;
  dp_cmd_t              cmd;
  dp_status_t           status;

  // Register decode.
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign coef_we = reg_wr && (reg_idx == REG_COEF_IMAG) && (32'(coef_index_q) < TAPS);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q     <= FACTOR_W'(1);
      coef_index_q <= '0;
      coef_re_q    <= '0;
      coef_im_q    <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_DEC_FACTOR: factor_q     <= pwdata[FACTOR_W-1:0];
        REG_COEF_INDEX: coef_index_q <= pwdata[IDX_W-1:0];
        REG_COEF_REAL:  coef_re_q    <= pwdata[COEF_BITS-1:0];
        REG_COEF_IMAG:  coef_im_q    <= pwdata[COEF_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_DEC_FACTOR: prdata = APB_DW'(factor_q);
      REG_COEF_INDEX: prdata = APB_DW'(coef_index_q);
      REG_COEF_REAL:  prdata = APB_DW'(coef_re_q);
      REG_COEF_IMAG:  prdata = APB_DW'(coef_im_q);
      default:        prdata = '0;
    endcase
  end

  dcf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .factor_i       (factor_q),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  dcf_dp #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .coef_we_i   (coef_we),
    .coef_addr_i (AW'(coef_index_q)),
    .coef_re_i   (coef_re_q),
    .coef_im_i   (pwdata[COEF_BITS-1:0]),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o)
  );

endmodule

// ===== sim/decimating_complex_fir_checker.sv =====
// ----------------------------------------------------------------------------
// decimating_complex_fir_checker
// Watches the sample, output and configuration channels of the decimating
// complex FIR filter and predicts every filtered word it must deliver.
// ----------------------------------------------------------------------------
// The checker keeps its own delay line, tap store and register copy, updated
// from the configuration writes and accepted sample words it observes. Each
// sample that closes a decimation interval queues one predicted word, and
// every delivered output word is compared field by field with the oldest one.
module decimating_complex_fir_checker #(
  parameter int unsigned TAPS        = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel.
  input  logic                          sample_valid_i,
  input  logic                          sample_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  // Output channel.
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] out_re_i,
  input  logic signed [SAMPLE_BITS-1:0] out_im_i,
  // Configuration port.
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [dcf_pkg::APB_AW-1:0]    paddr_i,
  input  logic [dcf_pkg::APB_DW-1:0]    pwdata_i,
  // Status for the testbench top.
  output int                            mismatches_o,
  output int                            words_owed_o,
  output int                            words_checked_o,
  output int                            samples_seen_o
);

  import dcf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } iq_word_t;

  // Predictor state: sample history, tap store and register copies.
  logic signed [SAMPLE_BITS-1:0] hist_re [TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_im [TAPS];
  logic signed [COEF_BITS-1:0]   tap_re  [TAPS];
  logic signed [COEF_BITS-1:0]   tap_im  [TAPS];
  int unsigned                   newest;
  int unsigned                   interval_count;
  logic [FACTOR_W-1:0]           rate;
  logic [IDX_W-1:0]              load_idx;
  logic signed [COEF_BITS-1:0]   staged_re;
  logic signed [COEF_BITS-1:0]   staged_im;

  // Filtered words still to be delivered, oldest first.
  iq_word_t filtered_due [$];

  int mismatches    = 0;
  int words_owed    = 0;
  int words_checked = 0;
  int samples_seen  = 0;

  assign mismatches_o    = mismatches;
  assign words_owed_o    = words_owed;
  assign words_checked_o = words_checked;
  assign samples_seen_o  = samples_seen;

  // Scale a Q1.(COEF_BITS-1) sum back to sample width, round half up, saturate.
  function automatic logic signed [SAMPLE_BITS-1:0] round_to_sample(input longint acc);
    longint r;
    longint peak;
    peak = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    r = (acc + (longint'(1) << (COEF_BITS - 2))) >>> (COEF_BITS - 1);
    if (r > peak) r = peak;
    if (r < -peak - 1) r = -peak - 1;
    return r[SAMPLE_BITS-1:0];
  endfunction

  // Enter one sample into the history; returns 1 with the filtered word when
  // the sample closes a decimation interval.
  function automatic logic accept_sample(input logic signed [SAMPLE_BITS-1:0] re,
                                         input logic signed [SAMPLE_BITS-1:0] im,
                                         output iq_word_t word);
    int unsigned eff;
    int unsigned k;
    int unsigned t;
    longint acc_re;
    longint acc_im;
    longint xr, xi, cr, ci;
    // A zero factor behaves as one, anything above the maximum as the maximum.
    if (rate == 0) eff = 1;
    else if (rate > FACTOR_MAX) eff = FACTOR_MAX;
    else eff = rate;
    hist_re[newest] = re;
    hist_im[newest] = im;
    interval_count++;
    if (interval_count < eff) begin
      newest = (newest + 1) % TAPS;
      return 1'b0;
    end
    interval_count = 0;
    acc_re = 0;
    acc_im = 0;
    // Tap 0 pairs with the newest sample, tap t with the one t steps older.
    for (t = 0; t < TAPS; t++) begin
      k = (newest + TAPS - t) % TAPS;
      xr = hist_re[k];
      xi = hist_im[k];
      cr = tap_re[t];
      ci = tap_im[t];
      acc_re += xr * cr - xi * ci;
      acc_im += xr * ci + xi * cr;
    end
    newest = (newest + 1) % TAPS;
    word.re = round_to_sample(acc_re);
    word.im = round_to_sample(acc_im);
    return 1'b1;
  endfunction

  // Compare delivered words, then track configuration writes and new samples.
  always @(posedge clk_i or negedge rst_ni) begin
    iq_word_t word;
    iq_word_t due;
    int t;
    if (!rst_ni) begin
      for (t = 0; t < TAPS; t++) begin
        hist_re[t] = '0;
        hist_im[t] = '0;
        tap_re[t]  = '0;
        tap_im[t]  = '0;
      end
      newest         = 0;
      interval_count = 0;
      rate           = 1;
      load_idx       = '0;
      staged_re      = '0;
      staged_im      = '0;
      filtered_due.delete();
      words_owed     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (filtered_due.size() == 0) begin
          mismatches++;
          $display("%0t: filtered word with none expected, actual re %0d im %0d",
                   $time, out_re_i, out_im_i);
        end else begin
          due = filtered_due.pop_front();
          words_checked++;
          if (out_re_i !== due.re) begin
            mismatches++;
            $display("%0t: out_re mismatch, expected %0d, actual %0d",
                     $time, due.re, out_re_i);
          end
          if (out_im_i !== due.im) begin
            mismatches++;
            $display("%0t: out_im mismatch, expected %0d, actual %0d",
                     $time, due.im, out_im_i);
          end
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[APB_AW-1:2]))
          REG_DEC_FACTOR: rate = pwdata_i[FACTOR_W-1:0];
          REG_COEF_INDEX: load_idx = pwdata_i[IDX_W-1:0];
          REG_COEF_REAL:  staged_re = pwdata_i[COEF_BITS-1:0];
          REG_COEF_IMAG: begin
            // Writing the imaginary part commits the staged pair.
            staged_im = pwdata_i[COEF_BITS-1:0];
            if (int'(load_idx) < TAPS) begin
              tap_re[load_idx] = staged_re;
              tap_im[load_idx] = staged_im;
            end
          end
          default: ;
        endcase
      end

      if (sample_valid_i && sample_ready_i) begin
        samples_seen++;
        if (accept_sample(sample_re_i, sample_im_i, word)) filtered_due.push_back(word);
      end
      words_owed = filtered_due.size();
    end
  end

endmodule

// ===== sim/decimating_complex_fir_top_tb.sv =====
// ----------------------------------------------------------------------------
// decimating_complex_fir_top_tb
// Stimulus and verdict for the decimating complex FIR filter.
// ----------------------------------------------------------------------------
// A short directed part drives extreme samples against extreme taps, checks
// round-half-up on a half-scale tap, and changes the decimation factor while
// a count is in progress. Random phases follow, each with a new factor
// (zero and values past the maximum included) and new, partly rewritten or
// unchanged taps, under random gaps on the sample side and stalls on the
// output side. The last phase runs with no idling. A checker beside the
// filter predicts and compares every filtered word.
module decimating_complex_fir_top_tb;
  import dcf_pkg::*;

  localparam int unsigned TAPS        = 64;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COEF_BITS   = 18;
  localparam int          ITEM_TARGET = 1550;
  localparam int          TAIL_ITEMS  = 150;
  // Wait out a full pass, with some margin, before touching registers.
  localparam int          SETTLE      = TAPS + 10;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_HALF  = COEF_BITS'(1 << (COEF_BITS - 2));

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          sample_valid_i = 1'b0;
  logic                          sample_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_re_i    = '0;
  logic signed [SAMPLE_BITS-1:0] sample_im_i    = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_re_o;
  logic signed [SAMPLE_BITS-1:0] out_im_o;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [APB_AW-1:0]             paddr          = '0;
  logic [APB_DW-1:0]             pwdata         = '0;
  logic [APB_DW-1:0]             prdata;
  logic                          pready;

  int mismatches;
  int words_owed;
  int words_checked;
  int samples_seen;

  // Idling controls: chance in percent of a burst before a word or a cycle.
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int items_sent = 0;
  int phases     = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  decimating_complex_fir_top #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_re_i    (sample_re_i),
    .sample_im_i    (sample_im_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_re_o       (out_re_o),
    .out_im_o       (out_im_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  decimating_complex_fir_checker #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) fir_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid_i),
    .sample_ready_i  (sample_ready_o),
    .sample_re_i     (sample_re_i),
    .sample_im_i     (sample_im_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_re_i        (out_re_o),
    .out_im_i        (out_im_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .mismatches_o    (mismatches),
    .words_owed_o    (words_owed),
    .words_checked_o (words_checked),
    .samples_seen_o  (samples_seen)
  );

  // Output side: ready drops in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(11, 0);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(9, 0))
      0: s = SAMPLE_MIN;
      1: s = SAMPLE_MAX;
      2: begin
        s = SAMPLE_BITS'($urandom_range(64, 0));
        s = s - SAMPLE_BITS'(32);
      end
      default: s = SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  // Mostly taps within +/- 2^scale_bits LSBs, now and then a full-scale one.
  function automatic logic signed [COEF_BITS-1:0] draw_coef(input int scale_bits);
    logic signed [COEF_BITS-1:0] c;
    case ($urandom_range(15, 0))
      0: c = COEF_MIN;
      1: c = COEF_MAX;
      default: begin
        c = COEF_BITS'($urandom);
        c = c >>> (COEF_BITS - 1 - scale_bits);
      end
    endcase
    return c;
  endfunction

  // One register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_tap(input int idx, input logic signed [COEF_BITS-1:0] cr,
                           input logic signed [COEF_BITS-1:0] ci);
    apb_write(REG_COEF_INDEX, APB_DW'(idx));
    apb_write(REG_COEF_REAL, APB_DW'(cr));
    apb_write(REG_COEF_IMAG, APB_DW'(ci));
  endtask

  // Load every tap, either alternating full-scale extremes or random values.
  task automatic load_kernel(input int scale_bits, input bit extremes);
    int t;
    for (t = 0; t < TAPS; t++) begin
      if (extremes) write_tap(t, (t % 2) ? COEF_MIN : COEF_MAX, (t % 2) ? COEF_MAX : COEF_MIN);
      else write_tap(t, draw_coef(scale_bits), draw_coef(scale_bits));
    end
  endtask

  // Present one sample word, after an optional gap, and hold it until taken.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                             input logic signed [SAMPLE_BITS-1:0] im);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      sample_valid_i <= 1'b0;
      repeat ($urandom_range(11, 0)) @(negedge clk_i);
    end
    @(negedge clk_i);
    sample_valid_i <= 1'b1;
    sample_re_i    <= re;
    sample_im_i    <= im;
    do @(posedge clk_i); while (!sample_ready_o);
    items_sent++;
  endtask

  // Stop sending, wait for every predicted word, then let the filter settle.
  task automatic drain_filter();
    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    while (words_owed != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin
    int n;
    int t;
    int len;
    int scale;
    logic [FACTOR_W-1:0] dec_factor;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extreme samples against alternating full-scale taps, factor zero.
    apb_write(REG_DEC_FACTOR, '0);
    load_kernel(17, 1'b1);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(0, 0);
    send_sample(1, -1);
    send_sample(-1, 1);
    send_sample(SAMPLE_MAX, 0);
    drain_filter();

    // Half-scale tap 0 only: odd sums land exactly on the rounding midpoint.
    for (t = 0; t < TAPS; t++) write_tap(t, (t == 0) ? COEF_HALF : '0, (t == 0) ? COEF_HALF : '0);
    apb_write(REG_DEC_FACTOR, APB_DW'(1));
    send_sample(1, 0);
    send_sample(-1, 0);
    send_sample(0, 1);
    send_sample(0, -1);
    send_sample(3, -2);
    drain_filter();

    // Lower the factor below the count already reached.
    apb_write(REG_DEC_FACTOR, APB_DW'(5));
    repeat (3) send_sample(draw_sample(), draw_sample());
    drain_filter();
    apb_write(REG_DEC_FACTOR, APB_DW'(2));
    repeat (3) send_sample(draw_sample(), draw_sample());

    // Random phases: new factor and taps each time, random idling.
    while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
      drain_filter();
      case ($urandom_range(9, 0))
        0: dec_factor = '0;
        1: dec_factor = FACTOR_W'($urandom_range(511, 257));
        2: dec_factor = FACTOR_W'($urandom_range(40, 9));
        default: dec_factor = FACTOR_W'($urandom_range(8, 1));
      endcase
      if (phases == 1) dec_factor = FACTOR_MAX;
      if (phases == 3) dec_factor = '1;
      if (phases == 1 || phases == 3) len = FACTOR_MAX + 2;
      else if (dec_factor > 40) len = $urandom_range(60, 20);
      else len = $urandom_range(120, 30);
      apb_write(REG_DEC_FACTOR, APB_DW'(dec_factor));

      case ($urandom_range(3, 0))
        0: scale = 6;
        1: scale = 10;
        2: scale = 13;
        default: scale = 17;
      endcase
      case ((phases == 0) ? 0 : $urandom_range(3, 0))
        0: load_kernel(scale, 1'b0);
        1: begin
          repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(3, 0))
              0: t = 0;
              1: t = TAPS - 1;
              default: t = $urandom_range(TAPS - 1, 0);
            endcase
            write_tap(t, draw_coef(scale), draw_coef(scale));
          end
        end
        // Re-commit the staged real part with a new imaginary part.
        2: apb_write(REG_COEF_IMAG, APB_DW'(draw_coef(scale)));
        default: ;
      endcase

      case ($urandom_range(3, 0))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 30;
        default: gap_pct = 60;
      endcase
      case ($urandom_range(3, 0))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 30;
        default: stall_pct = 60;
      endcase

      for (n = 0; n < len; n++) begin
        // Now and then hold back until every pending word is out.
        if ($urandom_range(199, 0) == 0) drain_filter();
        send_sample(draw_sample(), draw_sample());
      end
      phases++;
    end

    // Final stretch at full rate on both sides.
    gap_pct   = 0;
    stall_pct = 0;
    drain_filter();
    apb_write(REG_DEC_FACTOR, APB_DW'($urandom_range(3, 1)));
    repeat (TAIL_ITEMS) send_sample(draw_sample(), draw_sample());
    drain_filter();

    $display("Run covered %0d samples and %0d filtered words over %0d random phases,",
             samples_seen, words_checked, phases);
    $display("with factors from zero past the maximum and full-scale to half-scale taps.");
    if (mismatches == 0 && words_owed == 0) begin
      $display("decimating_complex_fir_top: match");
    end else begin
      $display("decimating_complex_fir_top: mismatch");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #10_000_000;
    $display("decimating_complex_fir_top: mismatch");
    $finish;
  end

endmodule
